/* src/cwga_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 weight-gradient accumulator.
package cwga_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned TAPS   = 9;
  localparam int unsigned DIM    = 3;
  localparam int unsigned IDX_W  = $clog2(TAPS);
  localparam int unsigned RC_W   = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] grad_out;
    logic signed [DATA_W-1:0] win_00;
    logic signed [DATA_W-1:0] win_01;
    logic signed [DATA_W-1:0] win_02;
    logic signed [DATA_W-1:0] win_10;
    logic signed [DATA_W-1:0] win_11;
    logic signed [DATA_W-1:0] win_12;
    logic signed [DATA_W-1:0] win_20;
    logic signed [DATA_W-1:0] win_21;
    logic signed [DATA_W-1:0] win_22;
    logic                     last_item;
  } in_beat_t;

  typedef struct packed {
    logic [RC_W-1:0]         tap_row;
    logic [RC_W-1:0]         tap_col;
    logic signed [ACC_W-1:0] grad_value;
    logic                    last_tap;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic acc_en;
    logic clear;
  } lane_ctl_t;

endpackage

/* src/cwga_lane.sv */
`timescale 1ns / 1ps
// One tap lane: registered product and saturating accumulator.
module cwga_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cwga_pkg::lane_ctl_t                 ctl_i,
  input  logic signed [cwga_pkg::DATA_W-1:0]  win_i,
  input  logic signed [cwga_pkg::DATA_W-1:0]  grad_i,
  output logic signed [cwga_pkg::ACC_W-1:0]   sum_o
);

  localparam int unsigned PROD_W = 2 * cwga_pkg::DATA_W;
  localparam int unsigned WIDE_W = (cwga_pkg::ACC_W > PROD_W) ? cwga_pkg::ACC_W : PROD_W;
  localparam int unsigned SUM_W  = WIDE_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - cwga_pkg::ACC_W + 1){1'b0}}, {(cwga_pkg::ACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W - cwga_pkg::ACC_W + 1){1'b1}}, {(cwga_pkg::ACC_W - 1){1'b0}}};

  logic signed [PROD_W-1:0]          prod_d, prod_q;
  logic signed [cwga_pkg::ACC_W-1:0] acc_d, acc_q;
  logic signed [SUM_W-1:0]           sum_wide;

  assign prod_d = win_i * grad_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum_wide = {{(SUM_W - cwga_pkg::ACC_W){acc_q[cwga_pkg::ACC_W-1]}}, acc_q}
             + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (sum_wide > SAT_MAX) begin
      sum_o = SAT_MAX[cwga_pkg::ACC_W-1:0];
    end else if (sum_wide < SAT_MIN) begin
      sum_o = SAT_MIN[cwga_pkg::ACC_W-1:0];
    end else begin
      sum_o = sum_wide[cwga_pkg::ACC_W-1:0];
    end
    acc_d = acc_q;
    if (ctl_i.acc_en) begin
      acc_d = ctl_i.clear ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  a_clear_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc_en && ctl_i.clear |=> acc_q == '0)
    else $error("lane accumulator not cleared after last beat");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.acc_en |=> $stable(acc_q))
    else $error("lane accumulator moved without an accumulate");

  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc_en && !ctl_i.clear && (sum_wide > SAT_MAX) |=> acc_q == SAT_MAX[cwga_pkg::ACC_W-1:0])
    else $error("positive overflow not clamped");

endmodule

/* src/cwga_drain.sv */
`timescale 1ns / 1ps
// Result buffer: snapshots the nine tap sums and sends them out in row-major order.
module cwga_drain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               snap_i,
  input  logic signed [cwga_pkg::ACC_W-1:0]  sums_i [cwga_pkg::TAPS],
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output cwga_pkg::out_beat_t                out_beat_o
);

  logic signed [cwga_pkg::ACC_W-1:0] buf_q [cwga_pkg::TAPS];
  logic                              busy_d, busy_q;
  logic [cwga_pkg::IDX_W-1:0]        idx_d, idx_q;
  logic [cwga_pkg::RC_W-1:0]         row_d, row_q, col_d, col_q;
  logic                              pop, at_end;

  assign pop    = busy_q && out_ready_i;
  assign at_end = idx_q == cwga_pkg::IDX_W'(cwga_pkg::TAPS - 1);

  always_ff @(posedge clk_i) begin
    if (snap_i) begin
      buf_q <= sums_i;
    end else if (pop) begin
      for (int i = 0; i < cwga_pkg::TAPS - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    row_d  = row_q;
    col_d  = col_q;
    if (snap_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      row_d  = '0;
      col_d  = '0;
    end else if (pop) begin
      if (at_end) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + 1'b1;
      if (col_q == cwga_pkg::RC_W'(cwga_pkg::DIM - 1)) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // free for a new snapshot in the cycle the ninth beat leaves
  assign busy_o                = busy_q && !(pop && at_end);
  assign out_valid_o           = busy_q;
  assign out_beat_o.tap_row    = row_q;
  assign out_beat_o.tap_col    = col_q;
  assign out_beat_o.grad_value = buf_q[0];
  assign out_beat_o.last_tap   = at_end;

  a_snap_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_i |-> !busy_q || (pop && at_end))
    else $error("snapshot while results still draining");

  a_snap_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_i |=> busy_q && row_q == '0 && col_q == '0)
    else $error("drain did not restart at tap zero");

  a_end_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && at_end && !snap_i |=> !busy_q)
    else $error("drain busy after ninth beat");

endmodule

/* src/conv3x3_weight_gradient_accumulator.sv */
`timescale 1ns / 1ps
// Each input beat carries one output-gradient sample and its 3x3 input window; nine lanes
// multiply and accumulate into 48-bit saturating sums, one item per cycle while not stalled.
// A beat with last_item set is added, then the nine sums are copied to a result buffer and
// the accumulators clear; the nine results leave row-major, one per cycle while out_ready_i
// is high, once that beat has passed the product register. The result buffer holds one run,
// so a last beat that reaches the accumulators while the previous run is still draining
// waits there: runs of nine or more keep one item per cycle while out_ready_i stays high.
module conv3x3_weight_gradient_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cwga_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cwga_pkg::out_beat_t out_beat_o
);

  logic signed [cwga_pkg::DATA_W-1:0] win  [cwga_pkg::TAPS];
  logic signed [cwga_pkg::ACC_W-1:0]  sums [cwga_pkg::TAPS];
  logic                               p_valid_d, p_valid_q;
  logic                               p_last_q;
  logic                               busy, stall, accept, advance, snap;
  cwga_pkg::lane_ctl_t                ctl;

  assign win[0] = in_beat_i.win_00;
  assign win[1] = in_beat_i.win_01;
  assign win[2] = in_beat_i.win_02;
  assign win[3] = in_beat_i.win_10;
  assign win[4] = in_beat_i.win_11;
  assign win[5] = in_beat_i.win_12;
  assign win[6] = in_beat_i.win_20;
  assign win[7] = in_beat_i.win_21;
  assign win[8] = in_beat_i.win_22;

  assign stall      = p_valid_q && p_last_q && busy;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = p_valid_q && !stall;
  assign snap       = advance && p_last_q;

  assign ctl.load   = accept;
  assign ctl.acc_en = advance;
  assign ctl.clear  = p_last_q;

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (advance) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      if (accept) begin
        p_last_q <= in_beat_i.last_item;
      end
    end
  end

  for (genvar t = 0; t < cwga_pkg::TAPS; t++) begin : g_lane
    cwga_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .win_i  (win[t]),
      .grad_i (in_beat_i.grad_out),
      .sum_o  (sums[t])
    );
  end

  cwga_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .sums_i      (sums),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap |=> out_valid_o && out_beat_o.tap_row == '0 && out_beat_o.tap_col == '0)
    else $error("last beat did not start a result run");

  a_tap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.tap_row != 2'd3 && out_beat_o.tap_col != 2'd3)
    else $error("tap index out of range");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> p_valid_q && p_last_q)
    else $error("stalled last beat lost");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 weight-gradient accumulator: directed rows, then random runs.
module tb_top;

  localparam longint ACC_MAX   = (longint'(1) <<< (cwga_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam int     RAND_BEATS = 400;
  localparam int     LIMIT     = 1000000;
  localparam int     TAIL      = 20;
  localparam int     MAX_PRINT = 100;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_mode_e;

  typedef struct {
    cwga_pkg::in_beat_t beat;
    bit                 pinned;
    longint             pinned_sum;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  cwga_pkg::in_beat_t  in_beat_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cwga_pkg::out_beat_t out_beat_o;

  conv3x3_weight_gradient_accumulator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  longint              filter_grad[cwga_pkg::TAPS];
  cwga_pkg::out_beat_t tap_expect_q[$];
  stim_row_t           stim_rows[$];
  cwga_pkg::out_beat_t want_tap;

  int       fail_cnt    = 0;
  int       print_cnt   = 0;
  int       beats_sent  = 0;
  int       runs_closed = 0;
  int       taps_seen   = 0;
  int       cycle_cnt   = 0;
  int       burst_left  = 0;
  bit       steady      = 1'b0;
  rx_mode_e rx_mode     = RX_ALWAYS;
  int       rx_span     = 0;
  int       rx_hold     = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d taps still expected", $realtime, cycle_cnt,
               tap_expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [cwga_pkg::DATA_W-1:0] window_tap(
    input cwga_pkg::in_beat_t b, input int k);
    case (k)
      0: return b.win_00;
      1: return b.win_01;
      2: return b.win_02;
      3: return b.win_10;
      4: return b.win_11;
      5: return b.win_12;
      6: return b.win_20;
      7: return b.win_21;
      default: return b.win_22;
    endcase
  endfunction

  function automatic void set_window_tap(inout cwga_pkg::in_beat_t b, input int k,
                                         input logic signed [cwga_pkg::DATA_W-1:0] v);
    case (k)
      0: b.win_00 = v;
      1: b.win_01 = v;
      2: b.win_02 = v;
      3: b.win_10 = v;
      4: b.win_11 = v;
      5: b.win_12 = v;
      6: b.win_20 = v;
      7: b.win_21 = v;
      default: b.win_22 = v;
    endcase
  endfunction

  // window ramps from base by step across the taps, row-major
  function automatic cwga_pkg::in_beat_t make_beat(input int g, input int base, input int step,
                                                   input bit last);
    cwga_pkg::in_beat_t b;
    b = '0;
    b.grad_out = cwga_pkg::DATA_W'(g);
    for (int k = 0; k < cwga_pkg::TAPS; k++)
      set_window_tap(b, k, cwga_pkg::DATA_W'(base + k * step));
    b.last_item = last;
    return b;
  endfunction

  function automatic logic signed [cwga_pkg::DATA_W-1:0] pick_sample();
    if ($urandom_range(0, 4) != 0) return cwga_pkg::DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0: return cwga_pkg::DATA_W'(-32768);
      1: return cwga_pkg::DATA_W'(32767);
      2: return cwga_pkg::DATA_W'(0);
      3: return cwga_pkg::DATA_W'(-1);
      default: return cwga_pkg::DATA_W'(1);
    endcase
  endfunction

  function automatic cwga_pkg::in_beat_t random_beat(input bit last);
    cwga_pkg::in_beat_t b;
    b = '0;
    b.grad_out = pick_sample();
    for (int k = 0; k < cwga_pkg::TAPS; k++) set_window_tap(b, k, pick_sample());
    b.last_item = last;
    return b;
  endfunction

  function automatic void add_row(input cwga_pkg::in_beat_t b, input bit pinned,
                                  input longint sum);
    stim_row_t r;
    r.beat       = b;
    r.pinned     = pinned;
    r.pinned_sum = sum;
    stim_rows.push_back(r);
  endfunction

  task automatic predict_taps(input cwga_pkg::in_beat_t b, input bit pinned,
                              input longint pinned_sum);
    longint              prod;
    longint              total;
    cwga_pkg::out_beat_t tap;
    for (int k = 0; k < cwga_pkg::TAPS; k++) begin
      prod  = longint'(window_tap(b, k)) * longint'(b.grad_out);
      total = filter_grad[k] + prod;
      if (total > ACC_MAX) total = ACC_MAX;
      else if (total < ACC_MIN) total = ACC_MIN;
      filter_grad[k] = total;
    end
    if (b.last_item) begin
      for (int k = 0; k < cwga_pkg::TAPS; k++) begin
        tap.tap_row    = cwga_pkg::RC_W'(k / cwga_pkg::DIM);
        tap.tap_col    = cwga_pkg::RC_W'(k % cwga_pkg::DIM);
        tap.grad_value = pinned ? pinned_sum[cwga_pkg::ACC_W-1:0]
                                : filter_grad[k][cwga_pkg::ACC_W-1:0];
        tap.last_tap   = (k == cwga_pkg::TAPS - 1);
        tap_expect_q.push_back(tap);
        filter_grad[k] = 0;
      end
      runs_closed++;
    end
  endtask

  task automatic send_beat(input cwga_pkg::in_beat_t b, input bit pinned,
                           input longint pinned_sum);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_taps(b, pinned, pinned_sum);
    beats_sent++;
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    fail_cnt++;
    if (print_cnt < MAX_PRINT) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $realtime, field, want, got);
      print_cnt++;
    end
  endtask

  // receiver: switches at random between several stall patterns
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_span <= $urandom_range(16, 80);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_COIN:     out_ready_i <= $urandom_range(0, 1);
      RX_PERIODIC: out_ready_i <= (rx_span % 4 != 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready_i <= ~out_ready_i;
          rx_hold     <= out_ready_i ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      taps_seen++;
      if (tap_expect_q.size() == 0) begin
        fail_cnt++;
        if (print_cnt < MAX_PRINT) begin
          $display("%0t unexpected tap beat: row %0d col %0d value %0d", $realtime,
                   out_beat_o.tap_row, out_beat_o.tap_col, $signed(out_beat_o.grad_value));
          print_cnt++;
        end
      end else begin
        want_tap = tap_expect_q.pop_front();
        if (out_beat_o.tap_row !== want_tap.tap_row)
          report_mismatch("tap_row", longint'(want_tap.tap_row),
                          longint'(out_beat_o.tap_row));
        if (out_beat_o.tap_col !== want_tap.tap_col)
          report_mismatch("tap_col", longint'(want_tap.tap_col),
                          longint'(out_beat_o.tap_col));
        if (out_beat_o.grad_value !== want_tap.grad_value)
          report_mismatch("grad_value", longint'($signed(want_tap.grad_value)),
                          longint'($signed(out_beat_o.grad_value)));
        if (out_beat_o.last_tap !== want_tap.last_tap)
          report_mismatch("last_tap", longint'(want_tap.last_tap),
                          longint'(out_beat_o.last_tap));
      end
    end
  end

  initial begin
    int run_len;
    int rand_sent;
    for (int k = 0; k < cwga_pkg::TAPS; k++) filter_grad[k] = 0;

    // single-beat runs with pinned sums, then single- and multi-beat runs against the predictor
    add_row(make_beat(0, 0, 0, 1'b1), 1'b1, 0);
    add_row(make_beat(-32768, -32768, 0, 1'b1), 1'b1, 64'sd1073741824);
    add_row(make_beat(32767, -32768, 0, 1'b1), 1'b1, -64'sd1073709056);
    add_row(make_beat(32767, 32767, 0, 1'b1), 1'b1, 64'sd1073676289);
    add_row(make_beat(-32768, 32767, 0, 1'b1), 1'b1, -64'sd1073709056);
    add_row(make_beat(16'h5555, 16'haaaa, 0, 1'b1), 1'b0, 0);
    add_row(make_beat(16'haaaa, 16'h5555, 0, 1'b1), 1'b0, 0);
    add_row(make_beat(1000, -16384, 4096, 1'b1), 1'b0, 0);
    add_row(make_beat(-1, 1, -1, 1'b0), 1'b0, 0);
    add_row(make_beat(-32768, 32767, -7000, 1'b0), 1'b0, 0);
    add_row(make_beat(32767, -32768, 7000, 1'b1), 1'b0, 0);
    for (int i = 0; i < 11; i++) add_row(make_beat(300 * i - 1500, 2000 * i, -911, 1'b0), 1'b0, 0);
    add_row(make_beat(-12345, 23456, 1234, 1'b1), 1'b0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_beat(stim_rows[i].beat, stim_rows[i].pinned,
                                     stim_rows[i].pinned_sum);

    rand_sent = 0;
    while (rand_sent < RAND_BEATS) begin
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      steady  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len; i++) send_beat(random_beat(i == run_len - 1), 1'b0, 0);
      rand_sent += run_len;
    end
    in_valid_i <= 1'b0;

    while (tap_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d windows in %0d runs, directed extremes first, then random runs.",
             beats_sent, runs_closed);
    $display("Checked %0d tap results under random sender gaps and receiver stalls, %0d errors.",
             taps_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* conv3x3_weight_gradient_accumulator.f */
src/cwga_pkg.sv
src/cwga_lane.sv
src/cwga_drain.sv
src/conv3x3_weight_gradient_accumulator.sv
bench/tb_top.sv
